[hdl/sidta_pkg.sv]
// Shared types, constants and the shift-add-3 step for the integer-to-decimal converter.
// No dependencies; used by sidta_bcd_stage and signed_int_to_decimal_ascii.
package sidta_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int NUM_DIGITS      = 10;
   localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
   localparam int STEPS_PER_STAGE = 8;
   localparam int NUM_STAGES      = VALUE_WIDTH / STEPS_PER_STAGE;
   localparam int DIGIT_IDX_WIDTH = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   // One number on its way through the conversion pipeline
   typedef struct packed {
      logic                   neg;
      logic [BCD_WIDTH-1:0]   bcd;
      logic [VALUE_WIDTH-1:0] bin;
   } conv_type;

   // One double-dabble step: add 3 to every digit of 5 or more, then shift one bit in
   function automatic conv_type dabble_step(input conv_type cur);
      conv_type             nxt;
      logic [BCD_WIDTH-1:0] adj;
      adj = cur.bcd;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if (adj[4*j +: 4] >= 4'd5) begin
            adj[4*j +: 4] = adj[4*j +: 4] + 4'd3;
         end
      end
      nxt.neg = cur.neg;
      nxt.bcd = {adj[BCD_WIDTH-2:0], cur.bin[VALUE_WIDTH-1]};
      nxt.bin = {cur.bin[VALUE_WIDTH-2:0], 1'b0};
      return nxt;
   endfunction

endpackage

[hdl/sidta_bcd_stage.sv]
// One pipeline stage of the binary-to-BCD converter: a fixed number of double-dabble steps.
// Depends on sidta_pkg for conv_type and dabble_step.
module sidta_bcd_stage
   import sidta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  conv_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output conv_type out_data
);

   logic     valid_ff;
   conv_type data_ff;
   conv_type data_in;
   conv_type step [STEPS_PER_STAGE+1];

   // Run this stage's share of the shift-add-3 steps
   always_comb begin
      step[0] = in_data;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         step[s+1] = dabble_step(step[s]);
      end
      data_in = step[STEPS_PER_STAGE];
   end

   // Advance when the stage is empty or its content moves on
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hdl/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per transfer.
// Depends on sidta_pkg and sidta_bcd_stage.
//
// Each 32-bit two's-complement number on req_ becomes its decimal text on rsp_, most
// significant character first, with a leading '-' for negative values and rsp_tlast on
// the final digit; zero gives a single '0' and leading zeros never appear. A number goes
// through a negate stage and four binary-to-BCD stages (eight shift-add-3 steps each),
// then a serializer that sends one character per cycle while rsp_tready is high. A number
// occupies the serializer for its 1 to 11 characters, and the next number loads while the
// last digit is sent; on its way out a number passes the negate, stage, serializer and
// output registers. The pipeline stages keep accepting numbers while the serializer
// drains, and back-pressure on rsp_ stalls them without losing or repeating anything.
module signed_int_to_decimal_ascii
   import sidta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast
);

   // Negate stage
   logic     s0_valid_ff;
   conv_type s0_data_ff;
   conv_type s0_data_in;

   // BCD stage chain
   logic     st_valid [NUM_STAGES+1];
   logic     st_ready [NUM_STAGES+1];
   conv_type st_data  [NUM_STAGES+1];

   // Serializer
   logic                       ser_valid_ff;
   logic                       ser_neg_ff;
   logic [DIGIT_IDX_WIDTH-1:0] ser_idx_ff;
   logic [3:0]                 ser_digit_ff [NUM_DIGITS];
   logic [DIGIT_IDX_WIDTH-1:0] top_idx;
   logic                       ser_ready;
   logic                       emit;

   // Output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;
   logic       out_ready;

   // Take the magnitude as unsigned so the most negative value converts
   always_comb begin
      s0_data_in.neg = req_tdata[VALUE_WIDTH-1];
      s0_data_in.bcd = '0;
      s0_data_in.bin = req_tdata[VALUE_WIDTH-1] ? (32'd0 - req_tdata) : req_tdata;
   end

   assign req_tready = !s0_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_data_ff <= s0_data_in;
      end
   end

   assign st_valid[0] = s0_valid_ff;
   assign st_data[0]  = s0_data_ff;

   // Binary-to-BCD pipeline
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_bcd
      sidta_bcd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[g]),
         .in_ready  (st_ready[g]),
         .in_data   (st_data[g]),
         .out_valid (st_valid[g+1]),
         .out_ready (st_ready[g+1]),
         .out_data  (st_data[g+1])
      );
   end

   // Find the most significant nonzero digit; zero keeps index 0
   always_comb begin
      top_idx = '0;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if (st_data[NUM_STAGES].bcd[4*j +: 4] != 4'd0) begin
            top_idx = DIGIT_IDX_WIDTH'(j);
         end
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign emit      = ser_valid_ff && out_ready;
   // Serializer frees up when empty or while sending its last digit
   assign ser_ready = !ser_valid_ff || (emit && !ser_neg_ff && ser_idx_ff == '0);
   assign st_ready[NUM_STAGES] = ser_ready;

   // Serializer control and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ser_ready) begin
            ser_valid_ff <= st_valid[NUM_STAGES];
         end
         if (out_ready) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   // Serializer payload: load a number, send the sign, then count digits down
   always_ff @(posedge clock) begin
      if (ser_ready && st_valid[NUM_STAGES]) begin
         ser_neg_ff <= st_data[NUM_STAGES].neg;
         ser_idx_ff <= top_idx;
         for (int j = 0; j < NUM_DIGITS; j++) begin
            ser_digit_ff[j] <= st_data[NUM_STAGES].bcd[4*j +: 4];
         end
      end else if (emit) begin
         if (ser_neg_ff) begin
            ser_neg_ff <= 1'b0;
         end else if (ser_idx_ff != '0) begin
            ser_idx_ff <= ser_idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (ser_neg_ff) begin
            rsp_char_ff <= ASCII_MINUS;
            rsp_last_ff <= 1'b0;
         end else begin
            rsp_char_ff <= ASCII_ZERO + {4'd0, ser_digit_ff[ser_idx_ff]};
            rsp_last_ff <= (ser_idx_ff == '0);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[dv/signed_int_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii: 32-bit integers in, their decimal text out.
// Depends on sidta_pkg and the block itself; a scoreboard class predicts every character.

import sidta_pkg::*;

typedef struct packed {
   logic [7:0] character;
   logic       is_last;
} text_char_type;

// Predicts the decimal text of each accepted number and checks characters in order
class decimal_text_board;
   text_char_type pending_chars[$];
   int unsigned   mismatches;
   int unsigned   numbers_noted;
   int unsigned   negatives_noted;
   int unsigned   longest_noted;
   int unsigned   chars_checked;

   // Spell one accepted number into the queue of expected characters
   function void note_number(logic [31:0] value);
      logic [31:0]   mag;
      logic [3:0]    digits [10];
      int            nd;
      text_char_type ch;
      mag = value[31] ? (32'd0 - value) : value;
      nd  = 0;
      do begin
         digits[nd] = 4'(mag % 32'd10);
         nd++;
         mag = mag / 32'd10;
      end while (mag != 32'd0 && nd < 10);
      numbers_noted++;
      if (value[31]) begin
         negatives_noted++;
         ch.character = ASCII_MINUS;
         ch.is_last   = 1'b0;
         pending_chars.push_back(ch);
      end
      if (value[31] && nd == 10) begin
         longest_noted++;
      end
      for (int i = nd - 1; i >= 0; i--) begin
         ch.character = ASCII_ZERO + 8'(digits[i]);
         ch.is_last   = (i == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   // Compare one received character against the oldest expected one
   function void check_char(logic [7:0] data, logic last);
      text_char_type want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
         $error("character 0x%02h (last %0b) arrived with nothing expected", data, last);
         mismatches++;
      end else begin
         want = pending_chars.pop_front();
         if (data !== want.character) begin
            $error("character: expected 0x%02h, got 0x%02h", want.character, data);
            mismatches++;
         end
         if (last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, last);
            mismatches++;
         end
      end
   endfunction

   function int unsigned pending();
      return pending_chars.size();
   endfunction
endclass

module signed_int_to_decimal_ascii_tb;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'd0;  // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] character
   logic        rsp_tlast;

   decimal_text_board board = new;
   bit                req_gaps_on = 1'b1;
   bit                rsp_gaps_on = 1'b1;
   int                rsp_stall_left = 0;

   signed_int_to_decimal_ascii DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check each character transfer, then pick the ready level for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_char(rsp_tdata, rsp_tlast);
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
      end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 13);
      end
      rsp_tready <= (rsp_stall_left == 0);
   end

   // Offer one number and hold it until the transfer happens
   task automatic send_number(input logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_number(value);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every expected character has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Random number: full-range bits, a chosen digit count, or a power-of-ten neighbor
   function automatic logic [31:0] random_number();
      longint      lo;
      longint      hi;
      longint      mag;
      int unsigned kind;
      int unsigned ndig;
      bit          neg;
      kind = $urandom_range(0, 19);
      neg  = $urandom_range(0, 1);
      ndig = $urandom_range(1, 10);
      lo   = 1;
      for (int i = 1; i < ndig; i++) begin
         lo = lo * 10;
      end
      if (kind < 8) begin
         return $urandom;
      end else if (kind < 17) begin
         hi = lo * 10 - 1;
         if (ndig == 1) begin
            lo = 0;
         end
         if (hi > 64'd2147483647) begin
            hi = 64'd2147483647;
         end
         mag = lo + longint'($urandom_range(0, int'(hi - lo)));
      end else begin
         mag = lo + $urandom_range(0, 2) - 1;
      end
      return neg ? (32'd0 - 32'(mag)) : 32'(mag);
   endfunction

   logic [31:0] directed_values [] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd7, -32'sd5, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
      -32'sd999999999, -32'sd1000000000, 32'd1999999999, 32'd2147483647,
      -32'sd2147483647, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa
   };

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Boundaries and digit-count edges first
      foreach (directed_values[i]) begin
         send_number(directed_values[i]);
      end
      wait_drained();

      // Random numbers in chunks, each with or without idling on either side
      for (int chunk = 0; chunk < 9; chunk++) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 30; n++) begin
            send_number(random_number());
         end
         if (chunk == 4) begin
            wait_drained();
         end
      end

      // Last stretch at full rate
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int n = 0; n < 40; n++) begin
         send_number(random_number());
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Converted %0d numbers (%0d negative, %0d of eleven characters).",
               board.numbers_noted, board.negatives_noted, board.longest_noted);
      $display("Checked %0d characters with back-pressure and gaps on both sides.",
               board.chars_checked);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
